// ----- rtl/pidl_pkg.sv -----
// Shared codes and types for the positional insert/delete list.
package pidl_pkg;

  // Widest index the list can need (DEPTH up to 64 needs a 7-bit count).
  localparam int IDX_W = 7;

  // Operation codes carried in the func field.
  localparam logic [2:0] FN_CLEAR    = 3'd0;
  localparam logic [2:0] FN_APPEND   = 3'd1;
  localparam logic [2:0] FN_INSERT   = 3'd2;
  localparam logic [2:0] FN_DELETE   = 3'd3;
  localparam logic [2:0] FN_TRAVERSE = 3'd4;

  // Status codes reported with every result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  // Commands broadcast to every cell of the chain.
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_APPEND = 3'd1;
  localparam logic [2:0] CELL_INSERT = 3'd2;
  localparam logic [2:0] CELL_DELETE = 3'd3;
  localparam logic [2:0] CELL_ROTATE = 3'd4;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [IDX_W-1:0] pos_idx;  // 0-based target position
    logic [IDX_W-1:0] count;    // entries before this update
  } pidl_cell_ctl_t;

endpackage

// ----- rtl/positional_insert_delete_list_core.sv -----
// Top level of the positional insert/delete list: control, status and the cell chain.
//
// Input stream (s_*): one transaction is one operation: clear, append, insert at a
// 1-based position, delete at a position, or traverse. Output stream (m_*): every
// operation yields one result transaction, except traverse of a non-empty list,
// which yields one per entry in order; m_tlast marks the final result of an operation.
// Append, insert and delete update all cells in parallel, and clear resets the entry
// count, in the cycle the operation is accepted; the result appears in the output
// register on the next cycle, so with the receiver ready one such operation is accepted every cycle.
// Traverse starts by entering the traversal state; then the chain rotates
// one step per emitted entry and is back in its original order after the last one.
// The next operation is taken once the traversal has finished and the output
// register is free or being drained.
// Rejected operations (full list, position out of range, empty list) leave the list
// unchanged and report a status code.
// Reset clears the entry count and the output valid; cell contents are not cleared
// and are never read before being written.
// While a result is valid and m_tready is low, the output register holds it, the
// traversal pauses and no new operation is accepted.
module positional_insert_delete_list_core #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // func[2:0], position[8:3], value[40:9], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // item[31:0], item_position[37:32], status[39:38],
                                 // length[45:40], zero fill
  output logic        m_tlast
);
  import pidl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TRAV = 1'b1;

  logic          state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] trav_idx, trav_idx_next;
  logic [CW-1:0] trav_pos;

  logic [31:0] out_item;
  logic [5:0]  out_pos;
  logic [1:0]  out_status;
  logic [5:0]  out_len;

  logic        res_load;
  logic [31:0] res_item;
  logic [5:0]  res_pos;
  logic [1:0]  res_status;
  logic        res_last;

  logic [2:0]  func;
  logic [5:0]  position;
  logic [31:0] value;
  logic        out_free;
  logic        accept;
  logic        full;
  logic [PW-1:0] pos_ext, cnt_ext;

  pidl_cell_ctl_t ctl;
  logic [31:0]    cell_q [DEPTH];

  assign func     = s_tdata[2:0];
  assign position = s_tdata[8:3];
  assign value    = s_tdata[40:9];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));
  assign pos_ext  = PW'(position);
  assign cnt_ext  = PW'(count);
  assign trav_pos = trav_idx + CW'(1);

  always_comb begin
    state_next    = state;
    count_next    = count;
    trav_idx_next = trav_idx;
    ctl.cmd       = CELL_HOLD;
    ctl.pos_idx   = IDX_W'(position) - IDX_W'(1);
    ctl.count     = IDX_W'(count);
    res_load      = 1'b0;
    res_item      = '0;
    res_pos       = '0;
    res_status    = STATUS_OK;
    res_last      = 1'b1;

    if (accept) begin
      res_load = 1'b1;
      case (func)
        FN_CLEAR: begin
          count_next = '0;
        end
        FN_APPEND: begin
          if (full) begin
            res_status = STATUS_FULL;
          end else begin
            ctl.cmd    = CELL_APPEND;
            count_next = count + CW'(1);
          end
        end
        FN_INSERT: begin
          if (full) begin
            res_status = STATUS_FULL;
          end else if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
            res_status = STATUS_RANGE;
          end else begin
            ctl.cmd    = CELL_INSERT;
            count_next = count + CW'(1);
          end
        end
        FN_DELETE: begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            res_status = STATUS_RANGE;
          end else begin
            ctl.cmd    = CELL_DELETE;
            count_next = count - CW'(1);
          end
        end
        FN_TRAVERSE: begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else begin
            res_load      = 1'b0;
            state_next    = ST_TRAV;
            trav_idx_next = '0;
          end
        end
        default: res_status = STATUS_OK;
      endcase
    end else if (state == ST_TRAV && out_free) begin
      // Emit the head cell and rotate the chain by one.
      ctl.cmd       = CELL_ROTATE;
      res_load      = 1'b1;
      res_item      = cell_q[0];
      res_pos       = 6'(trav_pos);
      res_last      = (trav_pos == count);
      trav_idx_next = trav_pos;
      if (trav_pos == count) state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      trav_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      trav_idx <= trav_idx_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item   <= res_item;
      out_pos    <= res_pos;
      out_status <= res_status;
      out_len    <= 6'(count_next);
      m_tlast    <= res_last;
    end
  end

  assign m_tdata = {2'b00, out_len, out_status, out_pos, out_item};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [31:0] left, right;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cell_q[g+1];
    end
    pidl_cell #(
      .INDEX(g)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .value(value),
      .left (left),
      .right(right),
      .first(cell_q[0]),
      .data (cell_q[g])
    );
  end

endmodule

// ----- rtl/pidl_cell.sv -----
// One storage cell of the list chain; takes data from its neighbors, the head cell or the input.
module pidl_cell #(
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  pidl_pkg::pidl_cell_ctl_t ctl,
  input  logic [31:0]             value,
  input  logic [31:0]             left,
  input  logic [31:0]             right,
  input  logic [31:0]             first,
  output logic [31:0]             data
);
  import pidl_pkg::*;

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  logic [IDX_W-1:0] count_m1;
  logic [31:0]      data_next;

  assign count_m1 = ctl.count - IDX_W'(1);

  always_comb begin
    data_next = data;
    case (ctl.cmd)
      CELL_APPEND: begin
        if (IDX == ctl.count) data_next = value;
      end
      CELL_INSERT: begin
        if (IDX == ctl.pos_idx) begin
          data_next = value;
        end else if (IDX > ctl.pos_idx && IDX <= ctl.count) begin
          data_next = left;
        end
      end
      CELL_DELETE: begin
        if (IDX >= ctl.pos_idx && IDX < count_m1) data_next = right;
      end
      CELL_ROTATE: begin
        // The head wraps around to the tail so a full traversal restores the list.
        if (IDX < count_m1) begin
          data_next = right;
        end else if (IDX == count_m1) begin
          data_next = first;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- dv/testbench.sv -----
// Testbench for positional_insert_delete_list_core: random and directed list operations.
`timescale 1ns / 1ps

module testbench;
  import pidl_pkg::*;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [31:0] item;
    logic [5:0]  item_position;
    logic [1:0]  status;
    logic [5:0]  length;
    logic        last;
  } list_result_t;

  // Shadow copy of the list that predicts every result and checks the outputs.
  class list_shadow;
    logic [31:0]  cells [DEPTH];
    int           count;
    list_result_t expected_results[$];
    int           errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_op(logic [2:0] fn, logic [5:0] pos, logic [31:0] val);
      logic [1:0] st;
      int         p;
      st = STATUS_OK;
      p = pos;
      case (fn)
        FN_CLEAR: begin
          count = 0;
        end
        FN_APPEND: begin
          if (count >= DEPTH) begin
            st = STATUS_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        FN_INSERT: begin
          if (count >= DEPTH) begin
            st = STATUS_FULL;
          end else if (p < 1 || p > count + 1) begin
            st = STATUS_RANGE;
          end else begin
            for (int i = count; i >= p; i--) cells[i] = cells[i-1];
            cells[p-1] = val;
            count++;
          end
        end
        FN_DELETE: begin
          if (count == 0) begin
            st = STATUS_EMPTY;
          end else if (p < 1 || p > count) begin
            st = STATUS_RANGE;
          end else begin
            for (int i = p - 1; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        FN_TRAVERSE: begin
          if (count == 0) begin
            expected_results.push_back('{32'd0, 6'd0, STATUS_EMPTY, 6'd0, 1'b1});
          end else begin
            for (int i = 0; i < count; i++) begin
              expected_results.push_back('{cells[i], 6'(i + 1), STATUS_OK, 6'(count),
                                          1'(i + 1 == count)});
            end
          end
          return;
        end
        default: ;
      endcase
      expected_results.push_back('{32'd0, 6'd0, st, 6'(count), 1'b1});
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [47:0] data, logic last_bit);
      list_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h last %b",
                 $time, data, last_bit);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("item", want.item, data[31:0]);
      compare_field("item_position", 32'(want.item_position), 32'(data[37:32]));
      compare_field("status", 32'(want.status), 32'(data[39:38]));
      compare_field("length", 32'(want.length), 32'(data[45:40]));
      compare_field("last", 32'(want.last), 32'(last_bit));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // func[2:0], position[8:3], value[40:9], zero fill
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // item[31:0], item_position[37:32], status[39:38],
                               // length[45:40], zero fill
  logic        m_tlast;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  list_shadow shadow = new();

  positional_insert_delete_list_core #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_result(m_tdata, m_tlast);
  end

  initial begin
    #5_000_000;
    $display("positional_insert_delete_list_core: mismatch");
    $finish;
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction,
  // with tvalid still high so back-to-back operations need no extra edge.
  task automatic send_op(logic [2:0] fn, logic [5:0] pos, logic [31:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, val, pos, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.note_op(fn, pos, val);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (shadow.pending() > 0) @(negedge clk);
  endtask

  task automatic send_fill_op();
    if ($urandom_range(1))
      send_op(FN_APPEND, 6'($urandom_range(63)), rand_value());
    else
      send_op(FN_INSERT, 6'($urandom_range(shadow.count + 1, 1)), rand_value());
  endtask

  task automatic send_drain_op();
    if (shadow.count == 0)
      send_op(FN_DELETE, 6'($urandom_range(63)), rand_value());
    else
      send_op(FN_DELETE, 6'($urandom_range(shadow.count, 1)), rand_value());
  endtask

  // Mostly well-formed bursts that grow or shrink the list, with traversals,
  // clears and some arbitrary operations mixed in.
  task automatic run_random(int n_items);
    int       sent;
    int       k;
    logic [2:0] fn;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          k = $urandom_range(40, 4);
          if (k > n_items - sent) k = n_items - sent;
          repeat (k) send_fill_op();
          sent += k;
          if ($urandom_range(1)) begin
            send_op(FN_TRAVERSE, 6'($urandom_range(63)), rand_value());
            sent++;
          end
        end
        4, 5: begin
          k = $urandom_range(20, 2);
          if (k > n_items - sent) k = n_items - sent;
          repeat (k) send_drain_op();
          sent += k;
        end
        6: begin
          send_op(FN_TRAVERSE, 6'($urandom_range(63)), rand_value());
          sent++;
        end
        7: begin
          send_op(FN_CLEAR, 6'($urandom_range(63)), rand_value());
          sent++;
        end
        default: begin
          repeat (4) begin
            fn = 3'($urandom_range(7));
            send_op(fn, 6'($urandom_range(63)), rand_value());
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, value extremes, positions at and past each bound,
    // every operation including the unused codes, and a clear.
    send_op(FN_TRAVERSE, 6'd0, 32'd0);
    send_op(FN_DELETE, 6'd1, 32'd0);
    send_op(FN_APPEND, 6'd0, 32'h7fff_ffff);
    send_op(FN_APPEND, 6'd63, 32'h8000_0000);
    send_op(FN_APPEND, 6'd0, 32'h0000_0000);
    send_op(FN_APPEND, 6'd0, 32'hffff_ffff);
    send_op(FN_INSERT, 6'd0, 32'h1234_5678);
    send_op(FN_INSERT, 6'd6, 32'h1234_5678);
    send_op(FN_INSERT, 6'd63, 32'h1234_5678);
    send_op(FN_INSERT, 6'd1, 32'h5a5a_5a5a);
    send_op(FN_INSERT, 6'd6, 32'ha5a5_a5a5);
    send_op(FN_INSERT, 6'd3, 32'h0f0f_f0f0);
    send_op(FN_DELETE, 6'd0, 32'd0);
    send_op(FN_DELETE, 6'd8, 32'd0);
    send_op(FN_DELETE, 6'd63, 32'd0);
    send_op(FN_DELETE, 6'd1, 32'd0);
    send_op(FN_DELETE, 6'd6, 32'd0);
    send_op(FN_DELETE, 6'd2, 32'd0);
    send_op(FN_TRAVERSE, 6'd0, 32'd0);
    send_op(3'd5, 6'd7, 32'hdead_beef);
    send_op(3'd6, 6'd0, 32'd0);
    send_op(3'd7, 6'd63, 32'hffff_ffff);
    send_op(FN_CLEAR, 6'd0, 32'd0);
    send_op(FN_TRAVERSE, 6'd0, 32'd0);

    // Fill to capacity, push against a full list, then stall the output for a
    // long stretch while operations keep coming.
    while (shadow.count < DEPTH) send_fill_op();
    send_op(FN_APPEND, 6'd5, rand_value());
    send_op(FN_INSERT, 6'd1, rand_value());
    send_op(FN_INSERT, 6'd33, rand_value());
    hold_cycles = 300;
    send_op(FN_TRAVERSE, 6'd0, 32'd0);
    repeat (6) send_drain_op();
    send_op(FN_TRAVERSE, 6'd0, 32'd0);
    wait_drained();
    while (shadow.count > 0) send_drain_op();
    run_random(22);

    send_idle_pct = 71;
    run_random(22);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 71;
    run_random(22);

    send_idle_pct = 31;
    recv_stall_pct = 31;
    run_random(22);

    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (shadow.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("positional_insert_delete_list_core: match");
    end else begin
      $display("positional_insert_delete_list_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list_core.sv
dv/testbench.sv
